/* sv/tgs_pkg.sv */
// ----------------------------------------------------------------------------
// Turmite grid stepper package
// Shared constants, payload and control types, and helper functions.
// ----------------------------------------------------------------------------
package tgs_pkg;

    localparam int MAX_COLS   = 256;
    localparam int MAX_ROWS   = 256;
    localparam int MAX_ANTS   = 16;
    localparam int MAX_COLORS = 11;
    localparam int MAX_STATES = 2;

    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int ANT_W     = $clog2(MAX_ANTS);
    localparam int TAPE_AW   = COL_W + ROW_W;
    localparam int TAPE_DEPTH = MAX_COLS * MAX_ROWS;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int DIM_W       = 9;
    localparam int CCOUNT_W    = 4;
    localparam int ACOUNT_W    = 5;
    localparam int COLOR_W     = 4;
    localparam int HEAD_W      = 3;
    localparam int RULE_BYTES  = 22;
    localparam int RULE_W      = RULE_BYTES * 8;
    localparam int RULE_IDX_W  = $clog2(RULE_BYTES);
    localparam int RULE_LIMIT  = (MAX_COLORS * MAX_STATES < RULE_BYTES) ?
                                 MAX_COLORS * MAX_STATES : RULE_BYTES;
    localparam int ANT_HOME    = 85;

    localparam logic [DIM_W-1:0]    RESET_COLS    = DIM_W'(170);
    localparam logic [DIM_W-1:0]    RESET_ROWS    = DIM_W'(170);
    localparam logic [CCOUNT_W-1:0] RESET_CCOUNT  = CCOUNT_W'(2);
    localparam logic [ACOUNT_W-1:0] RESET_ACOUNT  = ACOUNT_W'(1);
    localparam logic [63:0]         RESET_RULE_LO = 64'd20497;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEX_GRID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANT_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_MID    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_HIGH   = 3'd7;

    localparam logic FUNC_STEP    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    localparam logic [HEAD_W-1:0] DIR_NE = 3'd0;
    localparam logic [HEAD_W-1:0] DIR_E  = 3'd1;
    localparam logic [HEAD_W-1:0] DIR_SE = 3'd2;
    localparam logic [HEAD_W-1:0] DIR_SW = 3'd3;
    localparam logic [HEAD_W-1:0] DIR_W  = 3'd4;
    localparam logic [HEAD_W-1:0] DIR_NW = 3'd5;

    localparam logic [1:0] QUAD_N = 2'd0;
    localparam logic [1:0] QUAD_E = 2'd1;
    localparam logic [1:0] QUAD_S = 2'd2;
    localparam logic [1:0] QUAD_W = 2'd3;

    typedef struct packed {
        logic              func;
        logic [HEAD_W-1:0] start_direction;
    } tgs_in_t;

    typedef struct packed {
        logic [3:0]         ant_number;
        logic [7:0]         painted_col;
        logic [7:0]         painted_row;
        logic [COLOR_W-1:0] painted_color;
        logic [7:0]         ant_col_now;
        logic [7:0]         ant_row_now;
        logic [HEAD_W-1:0]  ant_heading_now;
        logic               last_of_run;
        logic               world_restarted;
    } tgs_out_t;

    typedef struct packed {
        logic [DIM_W-1:0]    cols;
        logic [DIM_W-1:0]    rows;
        logic                hex;
        logic [CCOUNT_W-1:0] color_count;
        logic [RULE_W-1:0]   rules;
    } tgs_cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [HEAD_W-1:0] heading;
        logic              mstate;
    } tgs_ant_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        tgs_ant_t           ant;
    } tgs_step_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RST_EMIT,
        ST_ADDR,
        ST_EXEC
    } tgs_state_t;

    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [ACOUNT_W-1:0] limit_ants(input logic [ACOUNT_W-1:0] v);
        logic [ACOUNT_W-1:0] r;
        if (v == '0)
        begin
            r = ACOUNT_W'(1);
        end
        else if (v > ACOUNT_W'(MAX_ANTS))
        begin
            r = ACOUNT_W'(MAX_ANTS);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [HEAD_W-1:0] square_norm(input logic [HEAD_W-1:0] d);
        logic [HEAD_W-1:0] t;
        logic [1:0]        c;
        t = (d > 3'd1) ? d - 3'd1 : d;
        c = t[1:0];
        return (c > 2'd1) ? {1'b0, c} + 3'd1 : {1'b0, c};
    endfunction

    function automatic logic [HEAD_W-1:0] start_heading(input logic hex,
                                                       input logic [HEAD_W-1:0] d);
        logic [HEAD_W-1:0] r;
        if (hex)
        begin
            r = (d >= 3'd6) ? d - 3'd6 : d;
        end
        else
        begin
            r = square_norm(d);
        end
        return r;
    endfunction

endpackage

/* sv/tgs_step_unit.sv */
// ----------------------------------------------------------------------------
// Turmite step unit
// Looks up the rule entry for one ant, turns it and moves it one cell.
// ----------------------------------------------------------------------------
module tgs_step_unit
    import tgs_pkg::*;
(
    input  tgs_cfg_t           cfg,
    input  tgs_ant_t           ant,
    input  logic [COLOR_W-1:0] cell_color,
    output tgs_step_t          step
);

    logic [7:0]            rule_bytes [RULE_BYTES];
    logic [RULE_IDX_W-1:0] rule_idx;
    logic [7:0]            entry;
    logic [2:0]            turn;
    logic [3:0]            hex_sum;
    logic [HEAD_W-1:0]     hex_head;
    logic [3:0]            turn_p1;
    logic [HEAD_W-1:0]     sq_turn;
    logic [HEAD_W-1:0]     sq_head_in;
    logic [HEAD_W-1:0]     sq_sum;
    logic [1:0]            quad;
    logic [DIM_W-1:0]      col_p1;
    logic [DIM_W-1:0]      row_p1;
    logic [DIM_W-1:0]      cols_m1;
    logic [DIM_W-1:0]      rows_m1;
    logic [COL_W-1:0]      col_inc;
    logic [COL_W-1:0]      col_dec;
    logic [ROW_W-1:0]      row_inc;
    logic [ROW_W-1:0]      row_dec;
    logic                  odd_row;

    always_comb
    begin
        for (int k = 0; k < RULE_BYTES; k++)
        begin
            rule_bytes[k] = cfg.rules[k*8 +: 8];
        end
    end

    assign rule_idx = RULE_IDX_W'({1'b0, cell_color}) +
                      (ant.mstate ? RULE_IDX_W'({1'b0, cfg.color_count}) : '0);
    assign entry    = (rule_idx < RULE_IDX_W'(RULE_LIMIT)) ? rule_bytes[rule_idx] : 8'd0;
    assign turn     = entry[6:4];

    assign hex_sum  = {1'b0, turn} + {1'b0, ant.heading};
    assign hex_head = (hex_sum >= 4'd12) ? HEAD_W'(hex_sum - 4'd12) :
                      (hex_sum >= 4'd6)  ? HEAD_W'(hex_sum - 4'd6)  : HEAD_W'(hex_sum);

    assign turn_p1    = {1'b0, turn} + 4'd1;
    assign sq_turn    = (turn > 3'd1) ? HEAD_W'(turn_p1 >> 1) : turn;
    assign sq_head_in = (ant.heading > 3'd1) ? ant.heading - 3'd1 : ant.heading;
    assign sq_sum     = sq_turn + sq_head_in;
    assign quad       = sq_sum[1:0];

    assign col_p1  = {1'b0, ant.col} + DIM_W'(1);
    assign row_p1  = {1'b0, ant.row} + DIM_W'(1);
    assign cols_m1 = cfg.cols - DIM_W'(1);
    assign rows_m1 = cfg.rows - DIM_W'(1);
    assign col_inc = (col_p1 == cfg.cols) ? '0 : col_p1[COL_W-1:0];
    assign row_inc = (row_p1 == cfg.rows) ? '0 : row_p1[ROW_W-1:0];
    assign col_dec = (ant.col == '0) ? cols_m1[COL_W-1:0] : ant.col - COL_W'(1);
    assign row_dec = (ant.row == '0) ? rows_m1[ROW_W-1:0] : ant.row - ROW_W'(1);
    assign odd_row = ant.row[0];

    always_comb
    begin
        step.color      = entry[3:0];
        step.ant.mstate = entry[7];
        step.ant.col    = ant.col;
        step.ant.row    = ant.row;
        if (cfg.hex)
        begin
            step.ant.heading = hex_head;
            unique case (hex_head)
                DIR_NE:
                begin
                    if (!odd_row)
                    begin
                        step.ant.col = col_inc;
                    end
                    step.ant.row = row_dec;
                end
                DIR_E:
                begin
                    step.ant.col = col_inc;
                end
                DIR_SE:
                begin
                    if (!odd_row)
                    begin
                        step.ant.col = col_inc;
                    end
                    step.ant.row = row_inc;
                end
                DIR_SW:
                begin
                    if (odd_row)
                    begin
                        step.ant.col = col_dec;
                    end
                    step.ant.row = row_inc;
                end
                DIR_W:
                begin
                    step.ant.col = col_dec;
                end
                default:
                begin
                    if (odd_row)
                    begin
                        step.ant.col = col_dec;
                    end
                    step.ant.row = row_dec;
                end
            endcase
        end
        else
        begin
            step.ant.heading = (quad > 2'd1) ? {1'b0, quad} + 3'd1 : {1'b0, quad};
            unique case (quad)
                QUAD_N: step.ant.row = row_dec;
                QUAD_E: step.ant.col = col_inc;
                QUAD_S: step.ant.row = row_inc;
                QUAD_W: step.ant.col = col_dec;
                default: step.ant.col = ant.col;
            endcase
        end
    end

endmodule

/* sv/turmite_grid_stepper_top.sv */
// ----------------------------------------------------------------------------
// Turmite grid stepper
// Steps up to sixteen turmites over a wrapping square or hexagonal tape.
// ----------------------------------------------------------------------------
// A step item works through each active ant in turn: a tape read in ST_ADDR, then
// rule, move and write-back in the shared step unit in ST_EXEC, which waits while
// the output is stalled. The next item is taken back in ST_IDLE.
// A restart item sweeps the tape one cell per cycle (all 65536 cells), then gives one
// beat per active ant per cycle while the output is not stalled. After reset the same
// clearing pass runs with input stalled; configuration writes are taken throughout.
module turmite_grid_stepper_top
    import tgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tgs_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tgs_out_t              out_data
);

    logic [DIM_W-1:0]    grid_cols_reg;
    logic [DIM_W-1:0]    grid_rows_reg;
    logic                hex_grid_reg;
    logic [CCOUNT_W-1:0] color_count_reg;
    logic [ACOUNT_W-1:0] ant_count_reg;
    logic [63:0]         rule_low_reg;
    logic [63:0]         rule_mid_reg;
    logic [47:0]         rule_high_reg;

    tgs_cfg_t            cfg;
    logic [ACOUNT_W-1:0] ants_eff;
    logic [ACOUNT_W-1:0] ants_m1;
    logic [ANT_W-1:0]    last_idx;

    tgs_state_t          state_reg;
    tgs_state_t          state_next;
    logic [ANT_W-1:0]    ant_idx_reg;
    logic [ANT_W-1:0]    ant_idx_next;
    logic [TAPE_AW-1:0]  clr_reg;
    logic [TAPE_AW-1:0]  clr_next;
    logic                emit_after_reg;
    logic                emit_after_next;
    tgs_ant_t            cur_reg;
    tgs_ant_t            cur_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    tgs_out_t            out_data_reg;
    tgs_out_t            out_data_next;

    tgs_ant_t            ant_reg [MAX_ANTS];
    logic                ant_we;
    tgs_ant_t            ant_wdata;
    logic                ant_restart;
    tgs_ant_t            restart_ant;

    logic [COLOR_W-1:0]  tape [TAPE_DEPTH];
    logic                mem_we;
    logic [TAPE_AW-1:0]  mem_waddr;
    logic [COLOR_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [TAPE_AW-1:0]  mem_raddr;
    logic [COLOR_W-1:0]  rd_reg;

    tgs_ant_t            sel_ant;
    tgs_ant_t            clamped;
    logic [DIM_W-1:0]    cols_m1;
    logic [DIM_W-1:0]    rows_m1;
    logic                out_free;
    tgs_step_t           step;

    assign cfg.cols        = limit_dim(grid_cols_reg, DIM_W'(MAX_COLS));
    assign cfg.rows        = limit_dim(grid_rows_reg, DIM_W'(MAX_ROWS));
    assign cfg.hex         = hex_grid_reg;
    assign cfg.color_count = color_count_reg;
    assign cfg.rules       = {rule_high_reg, rule_mid_reg, rule_low_reg};
    assign ants_eff        = limit_ants(ant_count_reg);
    assign ants_m1         = ants_eff - ACOUNT_W'(1);
    assign last_idx        = ants_m1[ANT_W-1:0];

    assign cols_m1 = cfg.cols - DIM_W'(1);
    assign rows_m1 = cfg.rows - DIM_W'(1);
    assign sel_ant = ant_reg[ant_idx_reg];

    always_comb
    begin
        clamped = sel_ant;
        if ({1'b0, sel_ant.col} >= cfg.cols)
        begin
            clamped.col = cols_m1[COL_W-1:0];
        end
        if ({1'b0, sel_ant.row} >= cfg.rows)
        begin
            clamped.row = rows_m1[ROW_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    tgs_step_unit u_step (
        .cfg        (cfg),
        .ant        (cur_reg),
        .cell_color (rd_reg),
        .step       (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg   <= RESET_COLS;
            grid_rows_reg   <= RESET_ROWS;
            hex_grid_reg    <= 1'b0;
            color_count_reg <= RESET_CCOUNT;
            ant_count_reg   <= RESET_ACOUNT;
            rule_low_reg    <= RESET_RULE_LO;
            rule_mid_reg    <= '0;
            rule_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_COLS:   grid_cols_reg   <= cfg_data[DIM_W-1:0];
                REG_GRID_ROWS:   grid_rows_reg   <= cfg_data[DIM_W-1:0];
                REG_HEX_GRID:    hex_grid_reg    <= cfg_data[0];
                REG_COLOR_COUNT: color_count_reg <= cfg_data[CCOUNT_W-1:0];
                REG_ANT_COUNT:   ant_count_reg   <= cfg_data[ACOUNT_W-1:0];
                REG_RULE_LOW:    rule_low_reg    <= cfg_data;
                REG_RULE_MID:    rule_mid_reg    <= cfg_data;
                REG_RULE_HIGH:   rule_high_reg   <= cfg_data[47:0];
                default:         rule_high_reg   <= rule_high_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            ant_idx_reg    <= '0;
            clr_reg        <= '0;
            emit_after_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ant_idx_reg    <= ant_idx_next;
            clr_reg        <= clr_next;
            emit_after_reg <= emit_after_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ANTS; i++)
            begin
                ant_reg[i].col     <= COL_W'(ANT_HOME);
                ant_reg[i].row     <= ROW_W'(ANT_HOME);
                ant_reg[i].heading <= '0;
                ant_reg[i].mstate  <= 1'b0;
            end
        end
        else if (ant_restart)
        begin
            for (int i = 0; i < MAX_ANTS; i++)
            begin
                ant_reg[i] <= restart_ant;
            end
        end
        else if (ant_we)
        begin
            ant_reg[ant_idx_reg] <= ant_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tape[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= tape[mem_raddr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ant_idx_next    = ant_idx_reg;
        clr_next        = clr_reg;
        emit_after_next = emit_after_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        in_stall        = 1'b1;
        ant_we          = 1'b0;
        ant_wdata       = step.ant;
        ant_restart     = 1'b0;
        restart_ant.col     = cfg.cols[COL_W:1];
        restart_ant.row     = cfg.rows[ROW_W:1];
        restart_ant.heading = start_heading(cfg.hex, in_data.start_direction);
        restart_ant.mstate  = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = {cur_reg.row, cur_reg.col};
        mem_wdata       = step.color;
        mem_re          = 1'b0;
        mem_raddr       = {clamped.row, clamped.col};

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ant_idx_next = '0;
                    if (in_data.func == FUNC_RESTART)
                    begin
                        ant_restart     = 1'b1;
                        clr_next        = '0;
                        emit_after_next = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + TAPE_AW'(1);
                if (clr_reg == '1)
                begin
                    ant_idx_next    = '0;
                    emit_after_next = 1'b0;
                    state_next      = emit_after_reg ? ST_RST_EMIT : ST_IDLE;
                end
            end
            ST_RST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.ant_number      = 4'(ant_idx_reg);
                    out_data_next.painted_col     = 8'(sel_ant.col);
                    out_data_next.painted_row     = 8'(sel_ant.row);
                    out_data_next.painted_color   = '0;
                    out_data_next.ant_col_now     = 8'(sel_ant.col);
                    out_data_next.ant_row_now     = 8'(sel_ant.row);
                    out_data_next.ant_heading_now = sel_ant.heading;
                    out_data_next.last_of_run     = (ant_idx_reg == last_idx);
                    out_data_next.world_restarted = 1'b1;
                    if (ant_idx_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ant_idx_next = ant_idx_reg + ANT_W'(1);
                    end
                end
            end
            ST_ADDR:
            begin
                mem_re     = 1'b1;
                cur_next   = clamped;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    mem_we                        = 1'b1;
                    ant_we                        = 1'b1;
                    out_valid_next                = 1'b1;
                    out_data_next.ant_number      = 4'(ant_idx_reg);
                    out_data_next.painted_col     = 8'(cur_reg.col);
                    out_data_next.painted_row     = 8'(cur_reg.row);
                    out_data_next.painted_color   = step.color;
                    out_data_next.ant_col_now     = 8'(step.ant.col);
                    out_data_next.ant_row_now     = 8'(step.ant.row);
                    out_data_next.ant_heading_now = step.ant.heading;
                    out_data_next.last_of_run     = (ant_idx_reg == last_idx);
                    out_data_next.world_restarted = 1'b0;
                    if (ant_idx_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ant_idx_next = ant_idx_reg + ANT_W'(1);
                        state_next   = ST_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/tgs_checker.sv */
// ----------------------------------------------------------------------------
// Turmite grid stepper checker
// Port-level assertions on the stepper's beats, bound to the top level.
// ----------------------------------------------------------------------------
module tgs_checker
    import tgs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input tgs_out_t              out_data
);

    // A result waiting to leave holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // Once an item is taken, the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accepted beat");

    // With the input open, only the closing beat of a run can still be pending.
    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_stall |-> out_data.last_of_run)
        else $error("input open while a run still has results to give");

    // While a beat that does not close its run is taken, the block stays busy.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_of_run |-> in_stall)
        else $error("run ended before its last beat");

    // Headings reported are always normalized.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.ant_heading_now <= DIR_NW)
        else $error("heading outside the six codes");

endmodule

bind turmite_grid_stepper_top tgs_checker u_tgs_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Turmite grid stepper testbench
// Sends step and restart beats under several grid, rule and ant settings and
// checks every result beat against an in-bench model of the ants and the tape.
// ----------------------------------------------------------------------------
module tb_top;
    import tgs_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RESTART_CAP = 8;
    localparam int RULE_SLOTS  = MAX_COLORS * MAX_STATES;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 20;

    localparam logic [HEAD_W-1:0] HEAD_NORTH = 3'd0;
    localparam logic [HEAD_W-1:0] HEAD_EAST  = 3'd1;
    localparam logic [HEAD_W-1:0] HEAD_SOUTH = 3'd3;
    localparam logic [HEAD_W-1:0] HEAD_WEST  = 3'd4;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        tgs_in_t               beat;
        logic                  typed;
        tgs_out_t              want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    tgs_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    tgs_out_t              out_data;

    logic [COLOR_W-1:0] tape [TAPE_DEPTH];
    logic [7:0]         ant_col [MAX_ANTS];
    logic [7:0]         ant_row [MAX_ANTS];
    logic [HEAD_W-1:0]  ant_head [MAX_ANTS];
    logic               ant_mst [MAX_ANTS];

    logic [DIM_W-1:0]    cfg_cols    = RESET_COLS;
    logic [DIM_W-1:0]    cfg_rows    = RESET_ROWS;
    logic                cfg_hex     = 1'b0;
    logic [CCOUNT_W-1:0] cfg_colors  = RESET_CCOUNT;
    logic [ACOUNT_W-1:0] cfg_ants    = RESET_ACOUNT;
    logic [63:0]         cfg_rule_lo = RESET_RULE_LO;
    logic [63:0]         cfg_rule_mid = '0;
    logic [47:0]         cfg_rule_hi = '0;

    tgs_out_t  due_results [$];
    plan_row_t plan [$];
    logic      typed_on = 1'b0;
    tgs_out_t  typed_res = '0;
    int        mismatches = 0;
    int        beats_taken = 0;
    int        restarts_taken = 0;
    int        cycle_count = 0;
    int        src_idle_pct = 22;
    int        sink_stall_pct = 59;

    turmite_grid_stepper_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int usable(input int v, input int top);
        return (v == 0) ? 1 : ((v > top) ? top : v);
    endfunction

    function automatic int ahead(input int v, input int lim);
        return (v + 1 == lim) ? 0 : v + 1;
    endfunction

    function automatic int behind(input int v, input int lim);
        return (v == 0) ? lim - 1 : v - 1;
    endfunction

    function automatic void advance_world(input tgs_in_t beat);
        int cols;
        int rows;
        int n;
        int c;
        int r;
        int d;
        int q;
        int k;
        int spot;
        int turn;
        logic [7:0] entry;
        logic [RULE_SLOTS*8-1:0] rules;
        tgs_out_t res;
        cols  = usable(cfg_cols, MAX_COLS);
        rows  = usable(cfg_rows, MAX_ROWS);
        n     = usable(cfg_ants, MAX_ANTS);
        rules = {cfg_rule_hi, cfg_rule_mid, cfg_rule_lo};
        res   = '0;
        if (beat.func == FUNC_RESTART)
        begin
            d = beat.start_direction;
            if (cfg_hex)
            begin
                d = d % 6;
            end
            else
            begin
                q = ((d > 1) ? d - 1 : d) % 4;
                d = (q > 1) ? q + 1 : q;
            end
            foreach (tape[j])
            begin
                tape[j] = '0;
            end
            for (int i = 0; i < MAX_ANTS; i++)
            begin
                ant_col[i]  = 8'(cols / 2);
                ant_row[i]  = 8'(rows / 2);
                ant_head[i] = d[2:0];
                ant_mst[i]  = 1'b0;
            end
            for (int i = 0; i < n; i++)
            begin
                res.ant_number      = 4'(i);
                res.painted_col     = 8'(cols / 2);
                res.painted_row     = 8'(rows / 2);
                res.painted_color   = '0;
                res.ant_col_now     = 8'(cols / 2);
                res.ant_row_now     = 8'(rows / 2);
                res.ant_heading_now = d[2:0];
                res.last_of_run     = (i + 1 == n);
                res.world_restarted = 1'b1;
                due_results.push_back(res);
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                c = ant_col[i];
                r = ant_row[i];
                d = ant_head[i];
                if (c >= cols)
                begin
                    c = cols - 1;
                end
                if (r >= rows)
                begin
                    r = rows - 1;
                end
                spot  = r * MAX_COLS + c;
                k     = int'(tape[spot]) + int'(ant_mst[i]) * int'(cfg_colors);
                entry = (k < RULE_SLOTS) ? rules[8*k +: 8] : 8'h00;
                turn  = entry[6:4];
                tape[spot] = entry[3:0];
                ant_mst[i] = entry[7];
                res.painted_col   = c[7:0];
                res.painted_row   = r[7:0];
                res.painted_color = entry[3:0];
                if (cfg_hex)
                begin
                    d = (turn + d) % 6;
                    case (d)
                        DIR_NE:
                        begin
                            if (r % 2 == 0) c = ahead(c, cols);
                            r = behind(r, rows);
                        end
                        DIR_E:   c = ahead(c, cols);
                        DIR_SE:
                        begin
                            if (r % 2 == 0) c = ahead(c, cols);
                            r = ahead(r, rows);
                        end
                        DIR_SW:
                        begin
                            if (r % 2 == 1) c = behind(c, cols);
                            r = ahead(r, rows);
                        end
                        DIR_W:   c = behind(c, cols);
                        default:
                        begin
                            if (r % 2 == 1) c = behind(c, cols);
                            r = behind(r, rows);
                        end
                    endcase
                end
                else
                begin
                    q = (((turn > 1) ? (turn + 1) / 2 : turn) + ((d > 1) ? d - 1 : d)) % 4;
                    d = (q > 1) ? q + 1 : q;
                    case (q)
                        QUAD_N:  r = behind(r, rows);
                        QUAD_E:  c = ahead(c, cols);
                        QUAD_S:  r = ahead(r, rows);
                        default: c = behind(c, cols);
                    endcase
                end
                ant_head[i] = d[2:0];
                ant_col[i]  = c[7:0];
                ant_row[i]  = r[7:0];
                res.ant_number      = 4'(i);
                res.ant_col_now     = c[7:0];
                res.ant_row_now     = r[7:0];
                res.ant_heading_now = d[2:0];
                res.last_of_run     = (i + 1 == n);
                res.world_restarted = 1'b0;
                due_results.push_back(res);
            end
        end
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t p;
        p      = '0;
        p.kind = ROW_CFG;
        p.idx  = idx;
        p.val  = val;
        return p;
    endfunction

    function automatic plan_row_t beat_row(input logic func, input logic [HEAD_W-1:0] dir);
        plan_row_t p;
        p                      = '0;
        p.kind                 = ROW_BEAT;
        p.beat.func            = func;
        p.beat.start_direction = dir;
        return p;
    endfunction

    function automatic plan_row_t typed_row(input logic func, input logic [HEAD_W-1:0] dir,
                                            input tgs_out_t want);
        plan_row_t p;
        p       = beat_row(func, dir);
        p.typed = 1'b1;
        p.want  = want;
        return p;
    endfunction

    function automatic logic [63:0] dim_value();
        logic [63:0] v;
        case ($urandom_range(9))
            0:       v = 64'd0;
            1:       v = 64'd256;
            2:       v = 64'($urandom_range(511));
            default: v = 64'($urandom_range(16, 1));
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GRID_COLS:   cfg_cols     = val[DIM_W-1:0];
            REG_GRID_ROWS:   cfg_rows     = val[DIM_W-1:0];
            REG_HEX_GRID:    cfg_hex      = val[0];
            REG_COLOR_COUNT: cfg_colors   = val[CCOUNT_W-1:0];
            REG_ANT_COUNT:   cfg_ants     = val[ACOUNT_W-1:0];
            REG_RULE_LOW:    cfg_rule_lo  = val;
            REG_RULE_MID:    cfg_rule_mid = val;
            default:         cfg_rule_hi  = val[47:0];
        endcase
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_beat(input tgs_in_t item);
        cfg_we <= 1'b0;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge clk)
    begin
        tgs_out_t want;
        if (out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result beat for ant %0d", out_data.ant_number);
                end
            end
            else
            begin
                want = due_results.pop_front();
                if (out_data.ant_number !== want.ant_number ||
                    out_data.painted_col !== want.painted_col ||
                    out_data.painted_row !== want.painted_row ||
                    out_data.painted_color !== want.painted_color ||
                    out_data.ant_col_now !== want.ant_col_now ||
                    out_data.ant_row_now !== want.ant_row_now ||
                    out_data.ant_heading_now !== want.ant_heading_now ||
                    out_data.last_of_run !== want.last_of_run ||
                    out_data.world_restarted !== want.world_restarted)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ant %0d/%0d paint (%0d,%0d)=%0d/(%0d,%0d)=%0d",
                                 want.ant_number, out_data.ant_number,
                                 want.painted_col, want.painted_row, want.painted_color,
                                 out_data.painted_col, out_data.painted_row,
                                 out_data.painted_color);
                        $display("  now (%0d,%0d) h%0d last %0d rs %0d, got (%0d,%0d) h%0d last %0d rs %0d",
                                 want.ant_col_now, want.ant_row_now, want.ant_heading_now,
                                 want.last_of_run, want.world_restarted,
                                 out_data.ant_col_now, out_data.ant_row_now,
                                 out_data.ant_heading_now, out_data.last_of_run,
                                 out_data.world_restarted);
                    end
                end
            end
        end
        if (in_valid && !in_stall)
        begin
            advance_world(in_data);
            // A directed beat with a single result carries its own expectation.
            if (typed_on)
            begin
                void'(due_results.pop_back());
                due_results.push_back(typed_res);
            end
            beats_taken++;
            if (in_data.func == FUNC_RESTART)
            begin
                restarts_taken++;
            end
            if (beats_taken < 60)
            begin
                src_idle_pct   = 22;
                sink_stall_pct = 59;
            end
            else if (beats_taken < 120)
            begin
                src_idle_pct   = 59;
                sink_stall_pct = 22;
            end
            else
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        tgs_in_t beat;
        foreach (tape[j])
        begin
            tape[j] = '0;
        end
        for (int i = 0; i < MAX_ANTS; i++)
        begin
            ant_col[i]  = 8'(ANT_HOME);
            ant_row[i]  = 8'(ANT_HOME);
            ant_head[i] = HEAD_NORTH;
            ant_mst[i]  = 1'b0;
        end

        plan.push_back(typed_row(FUNC_STEP, 3'd0,
                                 '{4'd0, 8'd85, 8'd85, 4'd1, 8'd86, 8'd85, HEAD_EAST, 1'b1, 1'b0}));
        plan.push_back(typed_row(FUNC_STEP, 3'd5,
                                 '{4'd0, 8'd86, 8'd85, 4'd1, 8'd86, 8'd86, HEAD_SOUTH, 1'b1, 1'b0}));
        plan.push_back(typed_row(FUNC_STEP, 3'd7,
                                 '{4'd0, 8'd86, 8'd86, 4'd1, 8'd85, 8'd86, HEAD_WEST, 1'b1, 1'b0}));
        plan.push_back(typed_row(FUNC_STEP, 3'd2,
                                 '{4'd0, 8'd85, 8'd86, 4'd1, 8'd85, 8'd85, HEAD_NORTH, 1'b1, 1'b0}));
        plan.push_back(typed_row(FUNC_STEP, 3'd1,
                                 '{4'd0, 8'd85, 8'd85, 4'd0, 8'd84, 8'd85, HEAD_WEST, 1'b1, 1'b0}));
        plan.push_back(typed_row(FUNC_RESTART, 3'd7,
                                 '{4'd0, 8'd85, 8'd85, 4'd0, 8'd85, 8'd85, HEAD_SOUTH, 1'b1, 1'b1}));
        plan.push_back(typed_row(FUNC_STEP, 3'd4,
                                 '{4'd0, 8'd85, 8'd85, 4'd1, 8'd84, 8'd85, HEAD_WEST, 1'b1, 1'b0}));
        plan.push_back(cfg_row(REG_HEX_GRID, 64'd1));
        plan.push_back(cfg_row(REG_GRID_COLS, 64'd256));
        plan.push_back(cfg_row(REG_GRID_ROWS, 64'd256));
        plan.push_back(cfg_row(REG_ANT_COUNT, 64'd16));
        plan.push_back(cfg_row(REG_COLOR_COUNT, 64'd11));
        plan.push_back(cfg_row(REG_RULE_LOW, 64'hF1E2_D3C4_B5A6_9788));
        plan.push_back(cfg_row(REG_RULE_MID, 64'h7F6E_5D4C_3B2A_190F));
        plan.push_back(cfg_row(REG_RULE_HIGH, 64'hBEEF_E7D6_C5B4_A392));
        plan.push_back(beat_row(FUNC_RESTART, 3'd6));
        plan.push_back(beat_row(FUNC_STEP, 3'd0));
        plan.push_back(beat_row(FUNC_STEP, 3'd7));
        plan.push_back(beat_row(FUNC_STEP, 3'd3));
        plan.push_back(cfg_row(REG_GRID_COLS, 64'd0));
        plan.push_back(cfg_row(REG_GRID_ROWS, 64'd511));
        plan.push_back(beat_row(FUNC_STEP, 3'd6));
        plan.push_back(beat_row(FUNC_STEP, 3'd1));
        plan.push_back(cfg_row(REG_HEX_GRID, 64'd0));
        plan.push_back(cfg_row(REG_ANT_COUNT, 64'd31));
        plan.push_back(cfg_row(REG_COLOR_COUNT, 64'd15));
        plan.push_back(beat_row(FUNC_STEP, 3'd2));
        plan.push_back(beat_row(FUNC_STEP, 3'd5));
        plan.push_back(cfg_row(REG_ANT_COUNT, 64'd0));
        plan.push_back(cfg_row(REG_GRID_COLS, 64'd4));
        plan.push_back(cfg_row(REG_GRID_ROWS, 64'd2));
        plan.push_back(cfg_row(REG_HEX_GRID, 64'd1));
        plan.push_back(typed_row(FUNC_RESTART, 3'd2,
                                 '{4'd0, 8'd2, 8'd1, 4'd0, 8'd2, 8'd1, DIR_SE, 1'b1, 1'b1}));
        plan.push_back(beat_row(FUNC_STEP, 3'd4));
        plan.push_back(beat_row(FUNC_STEP, 3'd3));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[p])
        begin
            if (plan[p].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[p].idx, plan[p].val);
            end
            else
            begin
                typed_on  = plan[p].typed;
                typed_res = plan[p].want;
                send_beat(plan[p].beat);
            end
        end
        typed_on = 1'b0;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_reg(REG_GRID_COLS, dim_value());
            write_reg(REG_GRID_ROWS, dim_value());
            write_reg(REG_HEX_GRID, 64'($urandom_range(1)));
            write_reg(REG_COLOR_COUNT, ($urandom_range(9) < 7) ? 64'($urandom_range(11, 2))
                                                               : 64'($urandom_range(15)));
            case ($urandom_range(9))
                0:       write_reg(REG_ANT_COUNT, 64'd0);
                1:       write_reg(REG_ANT_COUNT, 64'($urandom_range(31, 17)));
                default: write_reg(REG_ANT_COUNT, 64'($urandom_range(16, 1)));
            endcase
            write_reg(REG_RULE_LOW, {$urandom, $urandom});
            write_reg(REG_RULE_MID, {$urandom, $urandom});
            write_reg(REG_RULE_HIGH, {$urandom, $urandom});
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                beat.start_direction = 3'($urandom_range(7));
                beat.func            = FUNC_STEP;
                if (restarts_taken < RESTART_CAP &&
                    $urandom_range((k == 0) ? 2 : 29) == 0)
                begin
                    beat.func = FUNC_RESTART;
                end
                send_beat(beat);
            end
        end

        settle();
        repeat (40) @(negedge clk);
        if (mismatches == 0 && due_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
